>>> rtl/grid_height_map_range_max_top_macros.svh
// assertion macros for the height grid checker
`ifndef GRID_HEIGHT_MAP_RANGE_MAX_TOP_MACROS_SVH
`define GRID_HEIGHT_MAP_RANGE_MAX_TOP_MACROS_SVH

// checked while out of reset
`define GHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define GHM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/ghm_pkg.sv
// shared types, constants and helpers of the height grid
`default_nettype none

package ghm_pkg;

    // grid geometry
    localparam int CELL_X    = 32;
    localparam int CELL_Y    = 32;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;

    // field widths
    localparam int COORD_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int AREA_W   = 25;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CLIPX_W = $clog2(CELL_X + 1);
    localparam int CLIPY_W = $clog2(CELL_Y + 1);

    // reduction tree shape
    localparam int GROUP   = 8;
    localparam int NGROUPS = (GRID_COLS + GROUP - 1) / GROUP;
    localparam int GSUM_W  = $clog2(GROUP * CELL_X + 1);
    localparam int RSUM_W  = $clog2(GRID_COLS * CELL_X + 1);
    localparam int PROD_W  = RSUM_W + CLIPY_W;

    // operation codes
    localparam logic [1:0] OP_RAISE = 2'd0;
    localparam logic [1:0] OP_MAX   = 2'd1;
    localparam logic [1:0] OP_AREA  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SURF_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH  = 1'd1;

    localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(2048);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(2048);

    typedef struct packed {
        logic [1:0]         operation;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [HEIGHT_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] max_height;
        logic [AREA_W-1:0]   top_area;
    } rsp_t;

    typedef logic [GRID_COLS-1:0][HEIGHT_W-1:0] row_t;
    typedef logic [GRID_COLS-1:0][CLIPX_W-1:0]  clipx_t;

    // control travelling with a row read into the reduction pipeline
    typedef struct packed {
        logic               clear;
        logic               row_valid;
        logic               area_pass;
        logic [CLIPY_W-1:0] clip_y;
    } red_ctl_t;

    // length of a cell span clipped to [lo, hi]
    function automatic int unsigned clip_len(int unsigned base, int unsigned size,
                                             logic [COORD_W-1:0] lo,
                                             logic [COORD_W-1:0] hi);
        int unsigned a;
        int unsigned b;
        int unsigned e;
        a = base;
        b = base + size;
        e = 32'(hi) + 32'd1;
        if (a < 32'(lo)) a = 32'(lo);
        if (b > e) b = e;
        return (a < b) ? (b - a) : 32'd0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ghm_row_ram.sv
// row memory of cell heights, one grid row per word, rows read as zero until written
`default_nettype none

module ghm_row_ram import ghm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  row_t             wr_data,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_addr,
    output row_t             rd_data
);

    row_t                 mem [GRID_ROWS];
    row_t                 mem_rd_reg;
    logic [GRID_ROWS-1:0] vld_reg;
    logic                 vld_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // per-row written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_rd_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_rd_reg ? mem_rd_reg : '0;

endmodule

`default_nettype wire

>>> rtl/ghm_row_reduce.sv
// pipelined row reduction: max height and clipped area at the maximum
`default_nettype none

module ghm_row_reduce import ghm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  red_ctl_t            ctl,
    input  row_t                row,
    input  logic [GRID_COLS-1:0] mask,
    input  clipx_t              clipx,
    output logic                busy,
    output logic [HEIGHT_W-1:0] max_height,
    output logic [AREA_W-1:0]   top_area
);

    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic a_area_reg;
    logic b_area_reg;
    logic c_area_reg;

    logic [CLIPY_W-1:0] a_clipy_reg;
    logic [CLIPY_W-1:0] b_clipy_reg;

    logic [NGROUPS-1:0][HEIGHT_W-1:0] gmax_next;
    logic [NGROUPS-1:0][GSUM_W-1:0]   gsum_next;
    logic [NGROUPS-1:0][HEIGHT_W-1:0] a_gmax_reg;
    logic [NGROUPS-1:0][GSUM_W-1:0]   a_gsum_reg;

    logic [HEIGHT_W-1:0] b_max_next;
    logic [RSUM_W-1:0]   b_sum_next;
    logic [HEIGHT_W-1:0] b_max_reg;
    logic [RSUM_W-1:0]   b_sum_reg;

    logic [HEIGHT_W-1:0] c_max_reg;
    logic [PROD_W-1:0]   c_prod_reg;

    logic [HEIGHT_W-1:0] max_acc_reg;
    logic [AREA_W-1:0]   area_acc_reg;

    // stage a: per-group max and area sum over cells inside the span
    always_comb
    begin
        int idx;
        for (int g = 0; g < NGROUPS; g++)
        begin
            gmax_next[g] = '0;
            gsum_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                idx = g * GROUP + k;
                if (idx < GRID_COLS)
                begin
                    if (mask[idx])
                    begin
                        if (row[idx] > gmax_next[g])
                        begin
                            gmax_next[g] = row[idx];
                        end
                        if (row[idx] == max_acc_reg)
                        begin
                            gsum_next[g] = gsum_next[g] + GSUM_W'(clipx[idx]);
                        end
                    end
                end
            end
        end
    end

    // stage b: fold the groups
    always_comb
    begin
        b_max_next = '0;
        b_sum_next = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (a_gmax_reg[g] > b_max_next)
            begin
                b_max_next = a_gmax_reg[g];
            end
            b_sum_next = b_sum_next + RSUM_W'(a_gsum_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        a_gmax_reg  <= gmax_next;
        a_gsum_reg  <= gsum_next;
        a_clipy_reg <= ctl.clip_y;
        b_max_reg   <= b_max_next;
        b_sum_reg   <= b_sum_next;
        b_clipy_reg <= a_clipy_reg;
        c_max_reg   <= b_max_reg;
        c_prod_reg  <= PROD_W'(b_sum_reg) * PROD_W'(b_clipy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            a_area_reg   <= 1'b0;
            b_area_reg   <= 1'b0;
            c_area_reg   <= 1'b0;
            max_acc_reg  <= '0;
            area_acc_reg <= '0;
        end
        else
        begin
            a_valid_reg <= ctl.row_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            a_area_reg  <= ctl.area_pass;
            b_area_reg  <= a_area_reg;
            c_area_reg  <= b_area_reg;
            priority if (ctl.clear)
            begin
                max_acc_reg  <= '0;
                area_acc_reg <= '0;
            end
            else if (c_valid_reg && c_area_reg)
            begin
                area_acc_reg <= area_acc_reg + AREA_W'(c_prod_reg);
            end
            else if (c_valid_reg && (c_max_reg > max_acc_reg))
            begin
                max_acc_reg <= c_max_reg;
            end
            else
            begin
                // nothing to fold this cycle
            end
        end
    end

    assign busy       = a_valid_reg | b_valid_reg | c_valid_reg;
    assign max_height = max_acc_reg;
    assign top_area   = area_acc_reg;

endmodule

`default_nettype wire

>>> rtl/grid_height_map_range_max_top.sv
// top level of the coarse height grid with raise, max query and area query
`default_nettype none

// The block holds a 64 x 64 grid of 16-bit cell heights, zero after reset,
// one grid row per word of a row memory. A command word is taken when
// cmd_valid is high and cmd_stall low; the block takes one command at a time
// and holds cmd_stall high until that command is finished. Coordinates are
// mapped to cells by the cell size, and end cells are clamped to the cells in
// use set by the surface length and width registers. A raise lifts every
// covered cell to at least its level and gives no response. A max query
// returns the highest height in the rectangle; an area query also returns
// the summed area of the cells at that height, each clipped to the
// rectangle. An empty rectangle gives zero. The row memory is read one row
// a cycle, and an area query walks the rows twice. A response word waits in
// an output register while rsp_stall is high, and a new command is accepted
// meanwhile; a query that finishes while that word still waits holds
// cmd_stall high until the word is taken. The configuration port is always
// ready; it is to be written only while the block is idle, which the block
// itself does not enforce.

module grid_height_map_range_max_top import ghm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_SCAN,
        S_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] len_reg;
    logic [CFG_W-1:0] wid_reg;

    // command and span
    cmd_t                 cmd_reg;
    logic [ROW_W-1:0]     y0_reg;
    logic [ROW_W-1:0]     y1_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [GRID_COLS-1:0] mask_reg;
    clipx_t               clipx_reg;
    logic                 pass_reg;

    // read tag, aligned with the memory output
    logic               rowv_reg;
    logic               area_tag_reg;
    logic [CLIPY_W-1:0] clipy_reg;
    logic [ROW_W-1:0]   wb_row_reg;

    // response register
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic rsp_load;

    // span mapping, coordinates and cells in coordinate width plus one
    logic [COORD_W:0]     cols_raw;
    logic [COORD_W:0]     rows_raw;
    logic [COORD_W:0]     cols_n;
    logic [COORD_W:0]     rows_n;
    logic [COORD_W:0]     x0_full;
    logic [COORD_W:0]     y0_full;
    logic [COORD_W:0]     xe_cell;
    logic [COORD_W:0]     ye_cell;
    logic [COORD_W:0]     x1_full;
    logic [COORD_W:0]     y1_full;
    logic                 empty_next;
    logic                 op_known;
    logic [GRID_COLS-1:0] mask_next;
    clipx_t               clipx_next;
    logic [CLIPY_W-1:0]   clipy_next;

    // memory and reduction
    row_t                rd_data;
    row_t                wr_data;
    logic                wr_en;
    red_ctl_t            red_ctl;
    logic                red_busy;
    logic [HEIGHT_W-1:0] red_max;
    logic [AREA_W-1:0]   red_area;

    // config writes, taken every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LENGTH_RESET;
            wid_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SURF_LENGTH: len_reg <= cfg_data;
                REG_SURF_WIDTH:  wid_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // cells in use, clamp of end cells, per-column span mask and clipped width
    always_comb
    begin
        cols_raw = (COORD_W+1)'(({1'b0, len_reg} + (COORD_W+1)'(CELL_X - 1)) / CELL_X);
        rows_raw = (COORD_W+1)'(({1'b0, wid_reg} + (COORD_W+1)'(CELL_Y - 1)) / CELL_Y);
        cols_n = cols_raw;
        if (cols_raw < (COORD_W+1)'(1)) cols_n = (COORD_W+1)'(1);
        if (cols_raw > (COORD_W+1)'(GRID_COLS)) cols_n = (COORD_W+1)'(GRID_COLS);
        rows_n = rows_raw;
        if (rows_raw < (COORD_W+1)'(1)) rows_n = (COORD_W+1)'(1);
        if (rows_raw > (COORD_W+1)'(GRID_ROWS)) rows_n = (COORD_W+1)'(GRID_ROWS);

        x0_full = (COORD_W+1)'(cmd_reg.x_start / CELL_X);
        y0_full = (COORD_W+1)'(cmd_reg.y_start / CELL_Y);
        xe_cell = (COORD_W+1)'(cmd_reg.x_end / CELL_X);
        ye_cell = (COORD_W+1)'(cmd_reg.y_end / CELL_Y);
        x1_full = (xe_cell > cols_n - 1'b1) ? cols_n - 1'b1 : xe_cell;
        y1_full = (ye_cell > rows_n - 1'b1) ? rows_n - 1'b1 : ye_cell;
        empty_next = (x0_full > x1_full) || (y0_full > y1_full);

        for (int c = 0; c < GRID_COLS; c++)
        begin
            mask_next[c] = ((COORD_W+1)'(c) >= x0_full) && ((COORD_W+1)'(c) <= x1_full);
            clipx_next[c] = CLIPX_W'(clip_len(c * CELL_X, CELL_X,
                                              cmd_reg.x_start, cmd_reg.x_end));
        end
    end

    assign op_known = (cmd_reg.operation == OP_RAISE) || (cmd_reg.operation == OP_MAX) ||
                      (cmd_reg.operation == OP_AREA);

    // clipped height of the row being read
    assign clipy_next = CLIPY_W'(clip_len(32'(row_reg) * CELL_Y, CELL_Y,
                                          cmd_reg.y_start, cmd_reg.y_end));

    // finished query result goes into the response register once it is free
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // state machine, row walk and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            row_reg       <= '0;
            mask_reg      <= '0;
            clipx_reg     <= '0;
            pass_reg      <= 1'b0;
            rowv_reg      <= 1'b0;
            area_tag_reg  <= 1'b0;
            clipy_reg     <= '0;
            wb_row_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rowv_reg      <= (state_reg == S_SCAN);
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && rsp_stall);
            if (rsp_load)
            begin
                rsp_reg <= '{max_height: red_max, top_area: red_area};
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_MAP;
                    end
                end

                S_MAP:
                begin
                    y0_reg    <= ROW_W'(y0_full);
                    y1_reg    <= ROW_W'(y1_full);
                    row_reg   <= ROW_W'(y0_full);
                    mask_reg  <= mask_next;
                    clipx_reg <= clipx_next;
                    pass_reg  <= 1'b0;
                    priority if (!op_known)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (empty_next)
                    begin
                        state_reg <= (cmd_reg.operation == OP_RAISE) ? S_IDLE : S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    area_tag_reg <= pass_reg;
                    clipy_reg    <= clipy_next;
                    wb_row_reg   <= row_reg;
                    if (row_reg == y1_reg)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end

                S_WAIT:
                begin
                    // last write back done and reduction drained
                    if (!rowv_reg && !red_busy)
                    begin
                        priority if (cmd_reg.operation == OP_RAISE)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if ((cmd_reg.operation == OP_AREA) && !pass_reg)
                        begin
                            pass_reg  <= 1'b1;
                            row_reg   <= y0_reg;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // raise: read, lift covered cells, write back in the cycle after the read
    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            wr_data[c] = (mask_reg[c] && (rd_data[c] < cmd_reg.level)) ? cmd_reg.level
                                                                      : rd_data[c];
        end
    end

    assign wr_en = rowv_reg && (cmd_reg.operation == OP_RAISE);

    assign red_ctl = '{clear:     (state_reg == S_MAP),
                       row_valid: rowv_reg,
                       area_pass: area_tag_reg,
                       clip_y:    clipy_reg};

    ghm_row_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wb_row_reg),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (row_reg),
        .rd_data (rd_data)
    );

    ghm_row_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (red_ctl),
        .row        (rd_data),
        .mask       (mask_reg),
        .clipx      (clipx_reg),
        .busy       (red_busy),
        .max_height (red_max),
        .top_area   (red_area)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> rtl/ghm_port_checker.sv
// port checker for the height grid, bound to the top level
`default_nettype none

`include "grid_height_map_range_max_top_macros.svh"

module ghm_port_checker import ghm_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a stalled response word holds
    `GHM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response word changed")

    // a taken command always raises cmd_stall in the next cycle
    `GHM_ASSERT(a_busy_after_cmd, cmd_valid && !cmd_stall |=> cmd_stall, "no busy cycle after command word")

    // a response only comes out of work in progress
    `GHM_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> $past(cmd_stall), "response word without a command in progress")

    // quiet ports in reset
    `GHM_ASSERT_RST(a_reset_quiet, !rst_n |-> !rsp_valid && !cmd_stall, "ports not quiet in reset")

endmodule

bind grid_height_map_range_max_top ghm_port_checker u_port_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// testbench for the coarse height grid: raise, max query and area query
`timescale 1ns / 100ps

module tb;
    import ghm_pkg::*;

    // operation code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // generous bound on the whole run, far above the slowest correct run
    localparam int CYCLE_LIMIT = 1_000_000;
    // longest command is an area query over all rows
    localparam int SETTLE_CYCLES = 200;
    // receiver hold-off that backs the block up and stalls its command input
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 60;
    localparam int RANDOM_PER_PHASE = 165;
    localparam int NUM_PHASES = 6;

    // surface sizes per phase; the first phase runs on the reset values
    int unsigned length_plan [NUM_PHASES] = '{2048, 1, 2048, 700, 0, 33};
    int unsigned width_plan  [NUM_PHASES] = '{2048, 2048, 1, 333, 4095, 2047};
    // idle percentages per phase: sender heavy receiver light, swapped, none
    int unsigned send_plan   [NUM_PHASES] = '{13, 13, 64, 64, 0, 0};
    int unsigned recv_plan   [NUM_PHASES] = '{64, 64, 13, 13, 0, 0};

    logic clk;
    logic rst_n = 1'b1;

    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // predicted state of the block: cell heights and surface size
    logic [HEIGHT_W-1:0] heights [GRID_ROWS][GRID_COLS];
    int unsigned         length_reg = 2048;
    int unsigned         width_reg  = 2048;

    cmd_t pending_cmds [$];   // command words not yet offered
    rsp_t awaited_rsps [$];   // predicted response words, oldest first

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned accepted_cnt = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_cnt = 0;

    grid_height_map_range_max_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // grid starts at floor level, as after reset
    initial
    begin
        foreach (heights[r, c])
            heights[r][c] = '0;
    end

    // cells in use along one axis, held between one and the grid bound
    function automatic int unsigned cells_used(int unsigned size, int unsigned cell_sz,
                                               int unsigned bound);
        int unsigned n;
        n = (size + cell_sz - 1) / cell_sz;
        if (n < 1)
            n = 1;
        if (n > bound)
            n = bound;
        return n;
    endfunction

    // length of cell number idx along one axis that lies inside [lo, hi]
    function automatic int unsigned cell_overlap(int unsigned idx, int unsigned cell_sz,
                                                 int unsigned lo, int unsigned hi);
        int unsigned a;
        int unsigned b;
        a = idx * cell_sz;
        b = a + cell_sz;
        if (a < lo)
            a = lo;
        if (b > hi + 1)
            b = hi + 1;
        return (a < b) ? (b - a) : 0;
    endfunction

    // applies one accepted command word to the predicted grid; returns 1 with
    // the expected response word when the command gives one
    function automatic bit grid_step(input cmd_t c, output rsp_t r);
        int unsigned         x0;
        int unsigned         y0;
        int unsigned         x1;
        int unsigned         y1;
        int unsigned         cx;
        int unsigned         cy;
        bit                  empty;
        logic [HEIGHT_W-1:0] top;
        longint unsigned     sum;
        r = '0;
        top = '0;
        sum = 0;
        if (c.operation == OP_UNUSED)
            return 1'b0;
        x0 = 32'(c.x_start) / CELL_X;
        y0 = 32'(c.y_start) / CELL_Y;
        x1 = 32'(c.x_end) / CELL_X;
        y1 = 32'(c.y_end) / CELL_Y;
        if (x1 > cells_used(length_reg, CELL_X, GRID_COLS) - 1)
            x1 = cells_used(length_reg, CELL_X, GRID_COLS) - 1;
        if (y1 > cells_used(width_reg, CELL_Y, GRID_ROWS) - 1)
            y1 = cells_used(width_reg, CELL_Y, GRID_ROWS) - 1;
        empty = (x0 > x1) || (y0 > y1);
        if (c.operation == OP_RAISE)
        begin
            if (!empty)
                for (cy = y0; cy <= y1; cy++)
                    for (cx = x0; cx <= x1; cx++)
                        if (heights[cy][cx] < c.level)
                            heights[cy][cx] = c.level;
            return 1'b0;
        end
        if (!empty)
        begin
            for (cy = y0; cy <= y1; cy++)
                for (cx = x0; cx <= x1; cx++)
                    if (heights[cy][cx] > top)
                        top = heights[cy][cx];
            if (c.operation == OP_AREA)
                for (cy = y0; cy <= y1; cy++)
                    for (cx = x0; cx <= x1; cx++)
                        if (heights[cy][cx] == top)
                            sum += longint'(cell_overlap(cx, CELL_X, c.x_start, c.x_end))
                                 * cell_overlap(cy, CELL_Y, c.y_start, c.y_end);
        end
        r.max_height = top;
        r.top_area = sum[AREA_W-1:0];
        return 1'b1;
    endfunction

    // first corner: mostly on the surface, sometimes on cell edges or anywhere
    function automatic logic [COORD_W-1:0] pick_start(int unsigned span);
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 99);
        top = (span + 40 > 4095) ? 4095 : span + 40;
        if (r < 15)
            return COORD_W'($urandom_range(0, 4095));
        if (r < 25)
            return COORD_W'($urandom_range(0, 127) * 32 + ($urandom_range(0, 1) ? 31 : 0));
        return COORD_W'($urandom_range(0, top));
    endfunction

    // last corner: mostly a small span past the start, sometimes reversed
    // within the start cell, sometimes anywhere (often an empty rectangle)
    function automatic logic [COORD_W-1:0] pick_end(int unsigned start, int unsigned span,
                                                    int unsigned cell_sz);
        int unsigned r;
        int unsigned off;
        int unsigned e;
        r = $urandom_range(0, 99);
        off = start % cell_sz;
        if (r < 8 && off != 0)
            return COORD_W'(start - $urandom_range(1, off));
        if (r < 25)
            return COORD_W'($urandom_range(0, 4095));
        if (r < 80)
            e = start + $urandom_range(0, 96);
        else
            e = start + $urandom_range(0, span);
        return COORD_W'((e > 4095) ? 4095 : e);
    endfunction

    // random command word; levels climb with the phase so later raises still
    // show, and a small set of levels keeps ties at the top common
    function automatic cmd_t random_cmd(int unsigned phase);
        cmd_t        c;
        int unsigned r;
        r = $urandom_range(0, 99);
        c.operation = (r < 40) ? OP_RAISE : (r < 67) ? OP_MAX : (r < 97) ? OP_AREA : OP_UNUSED;
        c.x_start = pick_start(length_reg);
        c.y_start = pick_start(width_reg);
        c.x_end = pick_end(c.x_start, length_reg, CELL_X);
        c.y_end = pick_end(c.y_start, width_reg, CELL_Y);
        r = $urandom_range(0, 99);
        if (r < 60)
            c.level = HEIGHT_W'(phase * 2000 + $urandom_range(0, 5) * 100);
        else if (r < 90)
            c.level = HEIGHT_W'(phase * 2000 + $urandom_range(0, 3000));
        else
            c.level = HEIGHT_W'($urandom_range(0, 65535));
        return c;
    endfunction

    task automatic add_cmd(input logic [1:0] op, input int unsigned xs, input int unsigned ys,
                           input int unsigned xe, input int unsigned ye,
                           input int unsigned lv);
        cmd_t c;
        c.operation = op;
        c.x_start = COORD_W'(xs);
        c.y_start = COORD_W'(ys);
        c.x_end = COORD_W'(xe);
        c.y_end = COORD_W'(ye);
        c.level = HEIGHT_W'(lv);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // one register write on the configuration channel, only while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SURF_LENGTH)
            length_reg = val & 32'hFFF;
        else
            width_reg = val & 32'hFFF;
    endtask

    // command driver: a word is predicted at the edge that accepts it, and a
    // stalled word is held unchanged until it goes through
    always @(posedge clk)
    begin
        rsp_t r;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (grid_step(cmd, r))
                    awaited_rsps.insert(awaited_rsps.size(), r);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cmd <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off early in the run: the output register fills,
    // the next query waits behind it and the command input stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor: each accepted word is checked against the oldest
    // prediction, field by field
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $error("response word with none expected: max_height %0d top_area %0d",
                           rsp.max_height, rsp.top_area);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.max_height !== want.max_height)
                    begin
                        $error("max_height: expected %0d, got %0d",
                               want.max_height, rsp.max_height);
                        fail_count++;
                    end
                    if (rsp.top_area !== want.top_area)
                    begin
                        $error("top_area: expected %0d, got %0d",
                               want.top_area, rsp.top_area);
                        fail_count++;
                    end
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle);
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // run sequence: reset, then phases of directed and random words, each on
    // its own surface size and idling pattern, drained between phases
    initial
    begin
        int unsigned p;
        int unsigned k;
        // reset asserted at a clock edge and released at a later one
        @(posedge clk);
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            // registers change only once the block has drained
            if (p != 0)
            begin
                write_reg(REG_SURF_LENGTH, length_plan[p]);
                write_reg(REG_SURF_WIDTH, width_plan[p]);
            end
            @(posedge clk);
            send_idle <= send_plan[p];
            recv_idle <= recv_plan[p];
            if (p == 0)
            begin
                // fresh grid: whole surface reads zero, full area
                add_cmd(OP_MAX, 0, 0, 4095, 4095, 0);
                add_cmd(OP_AREA, 0, 0, 4095, 4095, 0);
                add_cmd(OP_RAISE, 0, 0, 31, 31, 1);
                // start cell beyond the clamped end cell: empty, no change
                add_cmd(OP_RAISE, 4095, 4095, 4095, 4095, 16'hFFFF);
                // top corner cell to the highest level through clamping
                add_cmd(OP_RAISE, 2016, 2016, 4095, 4095, 16'hFFFF);
                add_cmd(OP_AREA, 0, 0, 4095, 4095, 0);
                add_cmd(OP_MAX, 4095, 0, 4095, 4095, 0);
                // start past end on x, then on y: empty raise, then empty queries
                add_cmd(OP_RAISE, 100, 0, 50, 31, 500);
                add_cmd(OP_MAX, 100, 0, 50, 31, 0);
                add_cmd(OP_AREA, 0, 200, 31, 100, 0);
                add_cmd(OP_RAISE, 32, 0, 63, 31, 7);
                // reversed corners within one cell: height counts, area zero
                add_cmd(OP_AREA, 40, 0, 35, 31, 0);
                add_cmd(OP_AREA, 5, 3, 70, 40, 0);
                // unused code with a high level must leave the grid alone
                add_cmd(OP_UNUSED, 0, 0, 4095, 4095, 16'hFFFF);
                add_cmd(OP_MAX, 0, 0, 0, 0, 0);
                add_cmd(OP_RAISE, 0, 0, 4095, 4095, 0);
                add_cmd(OP_AREA, 2047, 2047, 2047, 2047, 16'hFFFF);
                add_cmd(OP_RAISE, 64, 64, 127, 4095, 16'h8000);
                add_cmd(OP_AREA, 0, 0, 4095, 4095, 16'h1234);
                add_cmd(OP_MAX, 2016, 2016, 2047, 2047, 0);
            end
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                pending_cmds.insert(pending_cmds.size(), random_cmd(p));
            // drained: all words taken, every response back, then settle for
            // a raise that may still be running
            do
                @(posedge clk);
            while (pending_cmds.size() != 0 || cmd_valid || awaited_rsps.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ghm_pkg.sv
rtl/ghm_row_ram.sv
rtl/ghm_row_reduce.sv
rtl/grid_height_map_range_max_top.sv
rtl/ghm_port_checker.sv
tb/tb.sv
